/* hw/rtl/aes128_pkg.sv */
// shared types, constants and round functions for the aes-128 block
package aes128_pkg;

	localparam int BLOCK_W = 128;
	localparam int HALF_W = 64;
	localparam int NUM_ROUNDS = 10;
	localparam int QUEUE_DEPTH = 2;
	localparam int ADDR_W = 5;

	localparam logic [ADDR_W-1:0] REG_KEY_HIGH = 5'h00;
	localparam logic [ADDR_W-1:0] REG_KEY_LOW = 5'h08;
	localparam logic [ADDR_W-1:0] REG_DECRYPT_MODE = 5'h10;

	typedef logic [BLOCK_W-1:0] block_t;

	typedef struct packed {
		logic   decrypt;
		block_t data;
	} job_t;

	function automatic logic [7:0] fwd_sbox(input logic [7:0] a);
		logic [7:0] tbl [0:255];
		tbl = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
		return tbl[a];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] a);
		logic [7:0] tbl [0:255];
		tbl = '{
		8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
		8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
		8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
		8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
		8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
		8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
		8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
		8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
		8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
		8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
		8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
		8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
		8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
		8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
		8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D};
		return tbl[a];
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] r);
		logic [7:0] v;
		case (r)
			4'd1: v = 8'h01;
			4'd2: v = 8'h02;
			4'd3: v = 8'h04;
			4'd4: v = 8'h08;
			4'd5: v = 8'h10;
			4'd6: v = 8'h20;
			4'd7: v = 8'h40;
			4'd8: v = 8'h80;
			4'd9: v = 8'h1b;
			4'd10: v = 8'h36;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

	// multiply by x in gf(2^8)
	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// byte n of a block sits at bits 127-8n
	function automatic logic [7:0] byte_of(input block_t b, input int n);
		return b[BLOCK_W-1-8*n -: 8];
	endfunction

	function automatic block_t sub_shift(input block_t s, input logic inverse);
		block_t t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (inverse)
					t[BLOCK_W-1-8*(r+4*((c+r)%4)) -: 8] = inv_sbox(byte_of(s, r+4*c));
				else
					t[BLOCK_W-1-8*(r+4*c) -: 8] = fwd_sbox(byte_of(s, r+4*((c+r)%4)));
			end
		end
		return t;
	endfunction

	function automatic block_t mix_fwd(input block_t s);
		block_t t;
		logic [7:0] a [4];
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) a[r] = byte_of(s, 4*c+r);
			for (int r = 0; r < 4; r++)
				t[BLOCK_W-1-8*(4*c+r) -: 8] = xt(a[r]) ^ xt(a[(r+1)%4]) ^ a[(r+1)%4]
					^ a[(r+2)%4] ^ a[(r+3)%4];
		end
		return t;
	endfunction

	function automatic block_t mix_inv(input block_t s);
		block_t t;
		logic [7:0] a [4];
		logic [7:0] x2 [4];
		logic [7:0] x4 [4];
		logic [7:0] x8 [4];
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				a[r] = byte_of(s, 4*c+r);
				x2[r] = xt(a[r]);
				x4[r] = xt(x2[r]);
				x8[r] = xt(x4[r]);
			end
			// 14, 11, 13, 9
			for (int r = 0; r < 4; r++)
				t[BLOCK_W-1-8*(4*c+r) -: 8] =
					(x8[r] ^ x4[r] ^ x2[r])
					^ (x8[(r+1)%4] ^ x2[(r+1)%4] ^ a[(r+1)%4])
					^ (x8[(r+2)%4] ^ x4[(r+2)%4] ^ a[(r+2)%4])
					^ (x8[(r+3)%4] ^ a[(r+3)%4]);
		end
		return t;
	endfunction

	// one step of the key schedule: round key r-1 to round key r
	function automatic block_t key_step(input block_t k, input logic [3:0] r);
		logic [31:0] w0, w1, w2, w3, t;
		w0 = k[127:96];
		w1 = k[95:64];
		w2 = k[63:32];
		w3 = k[31:0];
		t = {fwd_sbox(w3[23:16]), fwd_sbox(w3[15:8]), fwd_sbox(w3[7:0]), fwd_sbox(w3[31:24])};
		t = t ^ {rcon(r), 24'h0};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage

/* hw/rtl/aes128_if.sv */
// valid/ready channel carrying one 128-bit block as two halves
interface aes128_if;
	logic        valid;
	logic        ready;
	logic [63:0] block_high;
	logic [63:0] block_low;
	modport source (output valid, output block_high, output block_low, input ready);
	modport sink (input valid, input block_high, input block_low, output ready);
endinterface

interface aes128_res_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_high;
	logic [63:0] result_low;
	modport source (output valid, output result_high, output result_low, input ready);
	modport sink (input valid, input result_high, input result_low, output ready);
endinterface

/* hw/rtl/aes128_block_cipher_core.sv */
// aes-128 ecb top level
//  channel | dir | handshake     | word
//  in      | in  | valid/ready   | block_high, block_low
//  out     | out | valid/ready   | result_high, result_low
//  apb     | in  | psel/penable  | key_high, key_low, decrypt_mode
// one word per cycle sustained unless the output stalls or the key schedule is settling;
// words pass through the queue, the eleven-stage round pipeline and the output register.
// after reset or a key write the input is held off while the key schedule stages settle.
// a stalled output holds the pipeline after one skid word.
module aes128_block_cipher_core (
	input  logic clk,
	input  logic arst_n,
	aes128_if.sink in,
	aes128_res_if.source out,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [aes128_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic pready
);
	import aes128_pkg::*;

	logic   decrypt, avail, take, keys_ok;
	job_t   head;
	block_t round_keys [0:NUM_ROUNDS];

	assign pready = 1'b1;

	aes128_keys u_keys (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
		.decrypt, .keys_ok, .round_keys
	);

	aes128_front u_front (
		.clk, .arst_n, .in, .decrypt, .keys_ok, .take, .avail, .head
	);

	aes128_back u_back (
		.clk, .arst_n, .avail, .head, .take, .round_keys, .out
	);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |=> out.valid && $stable(out.result_high))
		else $error("result dropped under stall");
	a_skid: assert property (@(posedge clk) disable iff (!arst_n)
		u_back.skid_v_q |-> u_back.out_v_q)
		else $error("skid word without output word");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		u_back.skid_v_q |-> !take)
		else $error("queue popped while pipeline stalled");
endmodule

/* hw/rtl/aes128_keys.sv */
// configuration registers and round key schedule
module aes128_keys (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [aes128_pkg::ADDR_W-1:0] paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic decrypt,
	output logic keys_ok,
	output aes128_pkg::block_t round_keys [0:aes128_pkg::NUM_ROUNDS]
);
	import aes128_pkg::*;

	logic [63:0] key_high_q, key_low_q;
	logic        decrypt_q;
	logic        wr;
	logic [3:0]  settle_q;

	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			decrypt_q <= 1'b0;
		end else if (wr) begin
			case (paddr)
				REG_KEY_HIGH: key_high_q <= pwdata;
				REG_KEY_LOW: key_low_q <= pwdata;
				REG_DECRYPT_MODE: decrypt_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// input held off until the last schedule stage carries the new key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= 4'(NUM_ROUNDS + 1);
		end else if (wr && (paddr == REG_KEY_HIGH || paddr == REG_KEY_LOW)) begin
			settle_q <= 4'(NUM_ROUNDS + 1);
		end else if (settle_q != 4'd0) begin
			settle_q <= settle_q - 4'd1;
		end
	end

	assign keys_ok = (settle_q == 4'd0);

	always_comb begin
		case (paddr)
			REG_KEY_HIGH: prdata = key_high_q;
			REG_KEY_LOW: prdata = key_low_q;
			REG_DECRYPT_MODE: prdata = {63'h0, decrypt_q};
			default: prdata = '0;
		endcase
	end

	// one schedule step per stage, registered; the user must keep the key static while items run (unenforced)
	block_t rk_q [0:NUM_ROUNDS];
	always_ff @(posedge clk) begin
		rk_q[0] <= {key_high_q, key_low_q};
		for (int r = 1; r <= NUM_ROUNDS; r++)
			rk_q[r] <= key_step(rk_q[r-1], 4'(r));
	end

	assign round_keys = rk_q;
	assign decrypt = decrypt_q;
endmodule

/* hw/rtl/aes128_front.sv */
// input stage and short queue of tagged blocks
module aes128_front (
	input  logic clk,
	input  logic arst_n,
	aes128_if.sink in,
	input  logic decrypt,
	input  logic keys_ok,
	input  logic take,
	output logic avail,
	output aes128_pkg::job_t head
);
	import aes128_pkg::*;

	job_t mem_q [QUEUE_DEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in.ready = (cnt_q != 2'(QUEUE_DEPTH)) && keys_ok;
	assign push = in.valid && in.ready;
	assign avail = (cnt_q != 2'd0);
	assign pop = take && avail;
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= '{decrypt: decrypt, data: {in.block_high, in.block_low}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

/* hw/rtl/aes128_back.sv */
// unrolled round pipeline with output skid buffer
module aes128_back (
	input  logic clk,
	input  logic arst_n,
	input  logic avail,
	input  aes128_pkg::job_t head,
	output logic take,
	input  aes128_pkg::block_t round_keys [0:aes128_pkg::NUM_ROUNDS],
	aes128_res_if.source out
);
	import aes128_pkg::*;

	localparam int STAGES = NUM_ROUNDS + 1;

	logic   v_q [STAGES];
	logic   d_q [STAGES];
	block_t s_q [STAGES];
	logic   adv;
	block_t nxt [STAGES];

	// pipeline moves whenever the skid word is empty
	logic out_v_q, skid_v_q;
	block_t out_q, skid_q;
	assign adv = !skid_v_q;
	assign take = adv;

	always_comb begin
		nxt[0] = head.data ^ (head.decrypt ? round_keys[NUM_ROUNDS] : round_keys[0]);
		for (int i = 1; i < STAGES; i++) begin
			if (d_q[i-1]) begin
				if (i == NUM_ROUNDS)
					nxt[i] = sub_shift(s_q[i-1], 1'b1) ^ round_keys[0];
				else
					nxt[i] = mix_inv(sub_shift(s_q[i-1], 1'b1) ^ round_keys[NUM_ROUNDS-i]);
			end else begin
				if (i == NUM_ROUNDS)
					nxt[i] = sub_shift(s_q[i-1], 1'b0) ^ round_keys[NUM_ROUNDS];
				else
					nxt[i] = mix_fwd(sub_shift(s_q[i-1], 1'b0)) ^ round_keys[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s_q[0] <= nxt[0];
			d_q[0] <= head.decrypt;
			for (int i = 1; i < STAGES; i++) begin
				s_q[i] <= nxt[i];
				d_q[i] <= d_q[i-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STAGES; i++) v_q[i] <= 1'b0;
		end else if (adv) begin
			v_q[0] <= avail;
			for (int i = 1; i < STAGES; i++) v_q[i] <= v_q[i-1];
		end
	end

	// output register plus skid word
	logic last_v;
	assign last_v = v_q[STAGES-1] && adv;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (!out_v_q || out.ready) begin
				out_v_q <= skid_v_q || last_v;
				skid_v_q <= 1'b0;
			end else if (last_v) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || out.ready)
			out_q <= skid_v_q ? skid_q : s_q[STAGES-1];
		else if (last_v)
			skid_q <= s_q[STAGES-1];
	end

	assign out.valid = out_v_q;
	assign out.result_high = out_q[127:64];
	assign out.result_low = out_q[63:0];
endmodule

/* dv/aes128_block_cipher_core_tb.sv */
// self-checking testbench for the aes-128 ecb core: random and directed blocks, keys and modes
`timescale 1ns / 100ps

module aes128_block_cipher_core_tb;
	import aes128_pkg::*;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic pready;

	aes128_if in_ch ();
	aes128_res_if out_ch ();

	aes128_block_cipher_core dut (
		.clk(clk), .arst_n(arst_n), .in(in_ch.sink), .out(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor state
	logic [127:0] cipher_key;
	logic         decrypting;
	logic [127:0] round_keys [0:10];

	logic [127:0] pending_blocks [$];
	logic [127:0] expected_words [$];
	int unsigned  send_idle_pct, recv_idle_pct;
	int unsigned  errors, words_checked, enc_count, dec_count;
	bit           driving_enabled;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic logic [7:0] sbox_lookup(input logic [7:0] a, input logic inverse);
		logic [7:0] fwd [0:255];
		logic [7:0] r;
		fwd = '{
		8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
		8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
		8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
		8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
		8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
		8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
		8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
		8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
		8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
		8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
		8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
		8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
		8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
		8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
		8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
		8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16};
		r = 8'h00;
		if (!inverse) begin
			r = fwd[a];
		end else begin
			// inverse table derived by searching the forward one
			for (int i = 0; i < 256; i++)
				if (fwd[i] == a) r = i[7:0];
		end
		return r;
	endfunction

	function automatic logic [7:0] gf_times(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int k = 0; k < 8; k++) begin
			if (b[0]) p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
			b = b >> 1;
		end
		return p;
	endfunction

	function automatic void build_round_keys();
		logic [31:0] w [0:43];
		logic [31:0] t;
		logic [7:0]  rc;
		rc = 8'h01;
		for (int i = 0; i < 4; i++) w[i] = cipher_key[127-32*i -: 32];
		for (int i = 4; i < 44; i++) begin
			t = w[i-1];
			if (i % 4 == 0) begin
				t = {t[23:0], t[31:24]};
				t = {sbox_lookup(t[31:24], 1'b0), sbox_lookup(t[23:16], 1'b0),
					sbox_lookup(t[15:8], 1'b0), sbox_lookup(t[7:0], 1'b0)} ^ {rc, 24'h0};
				rc = gf_times(rc, 8'h02);
			end
			w[i] = w[i-4] ^ t;
		end
		for (int r = 0; r < 11; r++)
			round_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
	endfunction

	function automatic logic [127:0] cipher_block(input logic [127:0] blk, input logic inverse);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a [4];
		logic [7:0] m [4];
		logic [127:0] res;
		for (int n = 0; n < 16; n++) s[n] = blk[127-8*n -: 8];
		if (inverse) begin
			m = '{8'd14, 8'd11, 8'd13, 8'd9};
		end else begin
			m = '{8'd2, 8'd3, 8'd1, 8'd1};
		end
		for (int n = 0; n < 16; n++) s[n] ^= round_keys[inverse ? 10 : 0][127-8*n -: 8];
		for (int step = 1; step <= 10; step++) begin
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					if (inverse)
						t[r+4*((c+r)%4)] = sbox_lookup(s[r+4*c], 1'b1);
					else
						t[r+4*c] = sbox_lookup(s[r+4*((c+r)%4)], 1'b0);
			s = t;
			if (!inverse && step < 10) begin
				for (int c = 0; c < 4; c++) begin
					for (int r = 0; r < 4; r++) a[r] = s[4*c+r];
					for (int r = 0; r < 4; r++)
						s[4*c+r] = gf_times(a[r], m[0]) ^ gf_times(a[(r+1)%4], m[1])
							^ gf_times(a[(r+2)%4], m[2]) ^ gf_times(a[(r+3)%4], m[3]);
				end
			end
			for (int n = 0; n < 16; n++)
				s[n] ^= round_keys[inverse ? 10 - step : step][127-8*n -: 8];
			if (inverse && step < 10) begin
				for (int c = 0; c < 4; c++) begin
					for (int r = 0; r < 4; r++) a[r] = s[4*c+r];
					for (int r = 0; r < 4; r++)
						s[4*c+r] = gf_times(a[r], m[0]) ^ gf_times(a[(r+1)%4], m[1])
							^ gf_times(a[(r+2)%4], m[2]) ^ gf_times(a[(r+3)%4], m[3]);
				end
			end
		end
		for (int n = 0; n < 16; n++) res[127-8*n -: 8] = s[n];
		return res;
	endfunction

	// driver: one word per accepted handshake
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.block_high <= '0;
			in_ch.block_low <= '0;
		end else begin
			if (!in_ch.valid || in_ch.ready) begin
				if (driving_enabled && pending_blocks.size() > 0
					&& $urandom_range(99) >= send_idle_pct) begin
					in_ch.valid <= 1'b1;
					{in_ch.block_high, in_ch.block_low} <= pending_blocks[0];
					expected_words.push_back(cipher_block(pending_blocks[0], decrypting));
					if (decrypting) dec_count++;
					else enc_count++;
					void'(pending_blocks.pop_front());
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word %h_%h", $realtime,
						out_ch.result_high, out_ch.result_low);
					errors++;
				end else begin
					if (out_ch.result_high !== expected_words[0][127:64]) begin
						$display("%0t: result_high expected %h actual %h", $realtime,
							expected_words[0][127:64], out_ch.result_high);
						errors++;
					end
					if (out_ch.result_low !== expected_words[0][63:0]) begin
						$display("%0t: result_low expected %h actual %h", $realtime,
							expected_words[0][63:0], out_ch.result_low);
						errors++;
					end
					void'(expected_words.pop_front());
					words_checked++;
				end
			end
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [63:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (addr)
			REG_KEY_HIGH: cipher_key[127:64] = data;
			REG_KEY_LOW: cipher_key[63:0] = data;
			REG_DECRYPT_MODE: decrypting = data[0];
			default: ;
		endcase
		if (addr == REG_KEY_HIGH || addr == REG_KEY_LOW) build_round_keys();
		// key schedule settles
		repeat (12) @(posedge clk);
	endtask

	task automatic drain_blocks();
		while (pending_blocks.size() > 0 || expected_words.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// mostly random, with some all-ones, all-zero and sparse blocks
	function automatic logic [127:0] random_block();
		logic [127:0] b;
		case ($urandom_range(9))
			0: b = '0;
			1: b = '1;
			2: b = 128'h1 << $urandom_range(127);
			default: b = {rand64(), rand64()};
		endcase
		return b;
	endfunction

	task automatic set_key(input logic [127:0] k);
		apb_write(REG_KEY_HIGH, k[127:64]);
		apb_write(REG_KEY_LOW, k[63:0]);
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.block_high = '0;
		in_ch.block_low = '0;
		out_ch.ready = 1'b0;
		send_idle_pct = 19;
		recv_idle_pct = 65;
		errors = 0;
		words_checked = 0;
		enc_count = 0;
		dec_count = 0;
		driving_enabled = 1'b0;
		cipher_key = '0;
		decrypting = 1'b0;
		build_round_keys();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (14) @(posedge clk);
		driving_enabled = 1'b1;

		// reset key, forward cipher
		pending_blocks.push_back('0);
		pending_blocks.push_back('1);
		drain_blocks();

		// standard test vector, then back through the inverse cipher
		set_key(128'h000102030405060708090a0b0c0d0e0f);
		pending_blocks.push_back(128'h00112233445566778899aabbccddeeff);
		pending_blocks.push_back('0);
		pending_blocks.push_back('1);
		pending_blocks.push_back(128'h1);
		pending_blocks.push_back(128'h1 << 127);
		drain_blocks();
		apb_write(REG_DECRYPT_MODE, 64'h1);
		pending_blocks.push_back(128'h69c4e0d86a7b0430d8cdb78070b4c55a);
		pending_blocks.push_back('0);
		pending_blocks.push_back('1);
		drain_blocks();
		// only bit 0 of the mode counts, and an unmapped address changes nothing
		apb_write(REG_DECRYPT_MODE, 64'hffff_ffff_ffff_fffe);
		apb_write(5'h18, '1);
		pending_blocks.push_back(128'h00112233445566778899aabbccddeeff);
		drain_blocks();
		set_key('1);
		pending_blocks.push_back('0);
		pending_blocks.push_back('1);
		drain_blocks();
		apb_write(REG_DECRYPT_MODE, '1);
		pending_blocks.push_back('0);
		pending_blocks.push_back('1);
		drain_blocks();

		// random phases: three idling profiles with two keys each; odd phases decrypt, even phases pick the mode at random
		for (int phase = 0; phase < 12; phase++) begin
			if (phase == 4) begin
				send_idle_pct = 65;
				recv_idle_pct = 19;
			end else if (phase == 8) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if (phase % 2 == 0) set_key({rand64(), rand64()});
			apb_write(REG_DECRYPT_MODE, {rand64()} & 64'h3 | phase[0]);
			for (int i = 0; i < 94; i++) pending_blocks.push_back(random_block());
			drain_blocks();
		end

		if (errors == 0 && expected_words.size() == 0) begin
			$display("checked %0d words: %0d encrypted, %0d decrypted, across 9 keys",
				words_checked, enc_count, dec_count);
			$display("aes128_block_cipher_core: match");
		end else begin
			$display("checked %0d words, %0d errors, %0d left waiting",
				words_checked, errors, expected_words.size());
			$display("aes128_block_cipher_core: mismatch");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d words waiting", expected_words.size());
		$display("aes128_block_cipher_core: mismatch");
		$finish;
	end

endmodule
